// ===== rtl/core/packet_timestamp_table_macros.svh =====
// Assertion helpers used by the table datapath (pts_dp).
`ifndef PACKET_TIMESTAMP_TABLE_MACROS_SVH
`define PACKET_TIMESTAMP_TABLE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PTS_ASSERT_IMPL(NAME, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Check that a condition implies a consequence in the next cycle.
`define PTS_ASSERT_NEXT(NAME, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

// ===== rtl/core/pts_pkg.sv =====
package pts_pkg;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COUNT_W    = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_OWNER_ACTIVE = 2'd0;
  localparam cfg_idx_t CFG_OWNER_ID     = 2'd1;
  localparam cfg_idx_t CFG_RECORD_COUNT = 2'd2;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  module_id;
    logic [15:0] buffer_key;
    logic [31:0] stamp_in;
  } req_t;

  typedef struct packed {
    logic        recorded;
    logic        found;
    logic [31:0] stamp_out;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic write_rec;
    logic take_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic owner;
    logic is_query;
    logic hit;
    logic live;
  } dp_sts_t;

endpackage

// ===== rtl/core/pts_ctrl.sv =====
module pts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  output pts_pkg::dp_cmd_t cmd_o,
  input  pts_pkg::dp_sts_t sts_i
);

  pts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = pts_pkg::ST_CHECK;
        end
      end
      pts_pkg::ST_CHECK: begin
        // prime the scan pipeline with entry zero
        cmd_o.issue = 1'b1;
        if (!sts_i.owner) begin
          state_d = pts_pkg::ST_REPLY;
        end else if (sts_i.is_query) begin
          state_d = pts_pkg::ST_SCAN;
        end else begin
          cmd_o.write_rec = 1'b1;
          state_d         = pts_pkg::ST_REPLY;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d        = pts_pkg::ST_REPLY;
        end else if (!sts_i.live) begin
          state_d = pts_pkg::ST_REPLY;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      pts_pkg::ST_REPLY: begin
        done_o  = 1'b1;
        state_d = pts_pkg::ST_IDLE;
      end
      default: begin
        state_d = pts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pts_dp.sv =====
`include "packet_timestamp_table_macros.svh"

module pts_dp #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pts_pkg::req_t                      req_i,
  output pts_pkg::res_t                      res_o,
  input  logic                               cfg_we_i,
  input  pts_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  pts_pkg::dp_cmd_t                   cmd_i,
  output pts_pkg::dp_sts_t                   sts_o
);

  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned PW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  logic                          active_q;
  logic [7:0]                    owner_id_q;
  logic [pts_pkg::COUNT_W-1:0]   count_q;
  logic                          cfg_clear;

  pts_pkg::req_t                 req_q;
  pts_pkg::res_t                 res_q;
  logic [CW-1:0]                 n_eff;
  logic [PW-1:0]                 wptr_q;
  logic [CW-1:0]                 wsel;
  logic [CW-1:0]                 wnext;
  logic [MAX_RECORDS-1:0]        valid_q;

  logic [15:0]                   key_mem [MAX_RECORDS];
  logic [31:0]                   stamp_mem [MAX_RECORDS];

  logic [CW-1:0]                 idx_q;
  logic                          rd_en;
  logic                          rd_live_q;
  logic [PW-1:0]                 rd_idx_q;
  logic                          rd_valid_q;
  logic [15:0]                   rd_key_q;
  logic [31:0]                   rd_stamp_q;
  logic                          hit;

  // configuration decode
  always_comb begin
    unique case (cfg_idx_i) inside
      pts_pkg::CFG_OWNER_ACTIVE,
      pts_pkg::CFG_OWNER_ID,
      pts_pkg::CFG_RECORD_COUNT: cfg_clear = cfg_we_i;
      default:                   cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      owner_id_q <= '0;
      count_q    <= pts_pkg::COUNT_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pts_pkg::CFG_OWNER_ACTIVE: active_q   <= cfg_data_i[0];
        pts_pkg::CFG_OWNER_ID:     owner_id_q <= cfg_data_i;
        pts_pkg::CFG_RECORD_COUNT: count_q    <= cfg_data_i[pts_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the ring size to 1..MAX_RECORDS
  always_comb begin
    if (count_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(count_q) > MAX_RECORDS) begin
      n_eff = CW'(MAX_RECORDS);
    end else begin
      n_eff = CW'(count_q);
    end
  end

  always_comb begin
    wsel  = (CW'(wptr_q) >= n_eff) ? '0 : CW'(wptr_q);
    wnext = ((wsel + CW'(1)) >= n_eff) ? '0 : (wsel + CW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      valid_q <= '0;
    end else if (cfg_clear) begin
      wptr_q  <= '0;
      valid_q <= '0;
    end else if (cmd_i.write_rec) begin
      wptr_q              <= wnext[PW-1:0];
      valid_q[wsel[PW-1:0]] <= 1'b1;
    end else if (cmd_i.take_hit) begin
      valid_q[rd_idx_q] <= 1'b0;
    end
  end

  assign rd_en = cmd_i.issue && (idx_q < n_eff);

  // table storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_rec) begin
      key_mem[wsel[PW-1:0]]   <= req_q.buffer_key;
      stamp_mem[wsel[PW-1:0]] <= req_q.stamp_in;
    end
    if (rd_en) begin
      rd_key_q   <= key_mem[idx_q[PW-1:0]];
      rd_stamp_q <= stamp_mem[idx_q[PW-1:0]];
      rd_valid_q <= valid_q[idx_q[PW-1:0]];
      rd_idx_q   <= idx_q[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_live_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q     <= '0;
      rd_live_q <= 1'b0;
    end else if (cmd_i.issue) begin
      rd_live_q <= rd_en;
      if (rd_en) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  assign hit = rd_live_q && rd_valid_q && (rd_key_q == req_q.buffer_key)
               && (rd_stamp_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= '0;
    end else if (cmd_i.write_rec) begin
      res_q.recorded <= 1'b1;
    end else if (cmd_i.take_hit) begin
      res_q.found     <= 1'b1;
      res_q.stamp_out <= rd_stamp_q;
    end
  end

  assign res_o          = res_q;
  assign sts_o.owner    = active_q && (req_q.module_id == owner_id_q);
  assign sts_o.is_query = (req_q.req_type == pts_pkg::REQ_QUERY);
  assign sts_o.hit      = hit;
  assign sts_o.live     = rd_live_q;

  `PTS_ASSERT_IMPL(a_write_needs_owner, cmd_i.write_rec, sts_o.owner, "record write without owner")
  `PTS_ASSERT_IMPL(a_take_needs_hit, cmd_i.take_hit, hit, "entry consumed without a match")
  `PTS_ASSERT_NEXT(a_take_clears, cmd_i.take_hit && !cfg_clear, !valid_q[$past(rd_idx_q)],
                   "matched entry not cleared")

endmodule

// ===== rtl/core/packet_timestamp_table.sv =====
// Packet timestamp table: a ring of {buffer key, time stamp} records kept for
// one owning module.
//
// Request channel: drive req_i and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. Result channel: done_o is high for exactly one cycle
// with res_o valid; the receiver cannot hold it off, so capture it then.
//
// Sequence: a record request, or any request from a non-owner, passes the
// ownership check and then shows its result. A query from the owner walks
// the table one entry per cycle through the single registered read port of
// the record memory, from entry 0 until the first match or past the last of
// the n entries in use (n = ring size, 16 at reset), then shows its result;
// the next request may be taken in the cycle after done_o.
//
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once
// (0 owner_active, 1 owner_id, 2 record_count). Any write to one of these
// drops every record and rewinds the write pointer in that cycle; index 3 is
// ignored. Reset does the same and also returns the registers to their
// defaults (inactive, owner 0, 16 records). Write configuration only while idle.
module packet_timestamp_table #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  pts_pkg::req_t                  req_i,
  output logic                           done_o,
  output pts_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  pts_pkg::cfg_idx_t              cfg_idx_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // commands from the sequencer, status back from the table datapath
  pts_pkg::dp_cmd_t cmd;
  pts_pkg::dp_sts_t sts;

  // sequencer: accept, check ownership, record or scan, then show the result
  pts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // datapath: config registers, record memory, valid bits, scan pipeline
  pts_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
